>>> rtl/core/ppmhp_pkg.sv
// Shared constants for the PPM P6 header parser: byte codes, status and error codes.
`timescale 1ns / 1ps

package ppmhp_pkg;

  // Bytes the header grammar cares about.
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChSix     = 8'h36;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChLf      = 8'h0A;
  localparam logic [7:0] ChCr      = 8'h0D;
  localparam logic [7:0] ChTab     = 8'h09;

  // Decimal radix for the number accumulator.
  localparam int unsigned Radix = 10;

  localparam int unsigned OutBits = 16;
  localparam logic [OutBits-1:0] LastOffset = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_HEADER = 2'd0,
    ST_END    = 2'd1,
    ST_ERROR  = 2'd2,
    ST_IDLE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_MISSING   = 3'd2,
    ERR_TOO_LARGE = 3'd3,
    ERR_TOO_LONG  = 3'd4
  } error_e;

endpackage

>>> rtl/core/ppm_p6_header_parser_core.sv
// PPM P6 header parser: one file byte in, one status result out per transfer.
`timescale 1ns / 1ps

// Takes a binary PPM (P6) file one byte per transfer and returns one result per byte. The
// block sustains one byte per clock cycle while results are taken; each byte passes through
// the input register and then the result register, and the whole parse step (magic check,
// whitespace and comment skipping, multiply-by-ten accumulate) sits between those two
// registers. A stalled result register holds up a new byte only if the input register is
// full. When status is 1 the result also carries width, height, maxval and the offset of the
// first pixel byte; after the end of the header or an error every byte reports status 3 until
// a byte arrives with start_of_file set, which restarts the parse at that byte.
module ppm_p6_header_parser_core #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [15:0] max_value_o,
  output logic [15:0] header_length_o
);

  localparam int unsigned SumBits = VALUE_BITS + 5;

  typedef enum logic [2:0] {
    PH_P       = 3'd0,
    PH_SIX     = 3'd1,
    PH_WIDTH   = 3'd2,
    PH_COMMENT = 3'd3,
    PH_HEIGHT  = 3'd4,
    PH_MAXVAL  = 3'd5,
    PH_DONE    = 3'd6,
    PH_ERROR   = 3'd7
  } phase_e;

  // Pipeline control.
  logic s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic s1_sof_q;
  logic out_valid_q;
  logic adv;
  logic in_fire;
  logic s1_fire;

  // Parser state.
  phase_e phase_q, phase_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic seen_q, seen_d;
  logic [VALUE_BITS-1:0] wid_q, wid_d;
  logic [VALUE_BITS-1:0] hgt_q, hgt_d;
  logic [15:0] cnt_q, cnt_d;

  // Result register.
  ppmhp_pkg::status_e status_q, status_d;
  ppmhp_pkg::error_e err_q, err_d;
  logic [15:0] width_out_q, width_out_d;
  logic [15:0] height_out_q, height_out_d;
  logic [15:0] maxv_out_q, maxv_out_d;
  logic [15:0] hlen_out_q, hlen_out_d;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign s1_fire    = s1_valid_q && adv;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  // Parse step for the byte in the input register.
  always_comb begin
    phase_e ph;
    logic [VALUE_BITS-1:0] acc;
    logic seen;
    logic [VALUE_BITS-1:0] wid;
    logic [VALUE_BITS-1:0] hgt;
    logic [15:0] idx;
    logic is_space;
    logic is_numeral;
    logic [SumBits-1:0] sum;
    logic overflow;
    logic [16:0] hlen;
    logic [31:0] wid_ext;
    logic [31:0] hgt_ext;
    logic [31:0] acc_ext;

    // Start of file restarts from the reset state at this very byte.
    ph   = s1_sof_q ? PH_P : phase_q;
    acc  = s1_sof_q ? '0 : acc_q;
    seen = s1_sof_q ? 1'b0 : seen_q;
    wid  = s1_sof_q ? '0 : wid_q;
    hgt  = s1_sof_q ? '0 : hgt_q;
    idx  = s1_sof_q ? 16'd0 : cnt_q;

    is_space = (s1_byte_q == ppmhp_pkg::ChSpace) || (s1_byte_q == ppmhp_pkg::ChLf) ||
               (s1_byte_q == ppmhp_pkg::ChCr) || (s1_byte_q == ppmhp_pkg::ChTab);
    is_numeral = (s1_byte_q >= ppmhp_pkg::ChZero) && (s1_byte_q <= ppmhp_pkg::ChNine);

    sum = SumBits'(acc) * SumBits'(ppmhp_pkg::Radix)
        + SumBits'(s1_byte_q - ppmhp_pkg::ChZero);
    overflow = |sum[SumBits-1:VALUE_BITS];

    phase_d  = ph;
    acc_d    = acc;
    seen_d   = seen;
    wid_d    = wid;
    hgt_d    = hgt;
    cnt_d    = idx;
    status_d = ppmhp_pkg::ST_HEADER;
    err_d    = ppmhp_pkg::ERR_NONE;
    hlen     = 17'd0;

    width_out_d  = 16'd0;
    height_out_d = 16'd0;
    maxv_out_d   = 16'd0;
    hlen_out_d   = 16'd0;

    wid_ext = 32'(wid);
    hgt_ext = 32'(hgt);
    acc_ext = 32'(acc);

    if (ph == PH_DONE || ph == PH_ERROR) begin
      status_d = ppmhp_pkg::ST_IDLE;
    end else begin
      unique case (ph)
        PH_P: begin
          if (s1_byte_q == ppmhp_pkg::ChP) begin
            phase_d = PH_SIX;
          end else begin
            status_d = ppmhp_pkg::ST_ERROR;
            err_d    = ppmhp_pkg::ERR_MAGIC;
          end
        end
        PH_SIX: begin
          if (s1_byte_q == ppmhp_pkg::ChSix) begin
            phase_d = PH_WIDTH;
          end else begin
            status_d = ppmhp_pkg::ST_ERROR;
            err_d    = ppmhp_pkg::ERR_MAGIC;
          end
        end
        PH_COMMENT: begin
          if (s1_byte_q == ppmhp_pkg::ChLf) begin
            phase_d = PH_WIDTH;
          end
        end
        PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
          if (is_numeral) begin
            if (overflow) begin
              status_d = ppmhp_pkg::ST_ERROR;
              err_d    = ppmhp_pkg::ERR_TOO_LARGE;
            end else begin
              acc_d  = sum[VALUE_BITS-1:0];
              seen_d = 1'b1;
            end
          end else if (!seen) begin
            if (is_space) begin
              phase_d = ph;
            end else if (s1_byte_q == ppmhp_pkg::ChHash && ph == PH_WIDTH) begin
              phase_d = PH_COMMENT;
            end else begin
              status_d = ppmhp_pkg::ST_ERROR;
              err_d    = ppmhp_pkg::ERR_MISSING;
            end
          end else if (ph == PH_MAXVAL) begin
            // A non-space byte after maxval is itself the first pixel byte.
            status_d = ppmhp_pkg::ST_END;
            hlen     = is_space ? ({1'b0, idx} + 17'd1) : {1'b0, idx};
          end else if (is_space) begin
            if (ph == PH_WIDTH) begin
              wid_d   = acc;
              phase_d = PH_HEIGHT;
            end else begin
              hgt_d   = acc;
              phase_d = PH_MAXVAL;
            end
            acc_d  = '0;
            seen_d = 1'b0;
          end else begin
            status_d = ppmhp_pkg::ST_ERROR;
            err_d    = ppmhp_pkg::ERR_MISSING;
          end
        end
        default: begin
          status_d = ppmhp_pkg::ST_IDLE;
        end
      endcase

      if ((status_d == ppmhp_pkg::ST_HEADER && idx == ppmhp_pkg::LastOffset) ||
          (status_d == ppmhp_pkg::ST_END && hlen[16])) begin
        status_d = ppmhp_pkg::ST_ERROR;
        err_d    = ppmhp_pkg::ERR_TOO_LONG;
      end

      if (status_d == ppmhp_pkg::ST_ERROR) begin
        phase_d = PH_ERROR;
      end else if (status_d == ppmhp_pkg::ST_END) begin
        phase_d      = PH_DONE;
        width_out_d  = wid_ext[15:0];
        height_out_d = hgt_ext[15:0];
        maxv_out_d   = acc_ext[15:0];
        hlen_out_d   = hlen[15:0];
      end

      if (idx != ppmhp_pkg::LastOffset) begin
        cnt_d = idx + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s1_byte_q    <= 8'd0;
      s1_sof_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_P;
      acc_q        <= '0;
      seen_q       <= 1'b0;
      wid_q        <= '0;
      hgt_q        <= '0;
      cnt_q        <= 16'd0;
      status_q     <= ppmhp_pkg::ST_HEADER;
      err_q        <= ppmhp_pkg::ERR_NONE;
      width_out_q  <= 16'd0;
      height_out_q <= 16'd0;
      maxv_out_q   <= 16'd0;
      hlen_out_q   <= 16'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_fire) begin
        s1_byte_q <= data_byte_i;
        s1_sof_q  <= start_of_file_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        phase_q      <= phase_d;
        acc_q        <= acc_d;
        seen_q       <= seen_d;
        wid_q        <= wid_d;
        hgt_q        <= hgt_d;
        cnt_q        <= cnt_d;
        status_q     <= status_d;
        err_q        <= err_d;
        width_out_q  <= width_out_d;
        height_out_q <= height_out_d;
        maxv_out_q   <= maxv_out_d;
        hlen_out_q   <= hlen_out_d;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign error_code_o    = err_q;
  assign image_width_o   = width_out_q;
  assign image_height_o  = height_out_q;
  assign max_value_o     = maxv_out_q;
  assign header_length_o = hlen_out_q;

`ifndef NO_ASSERTIONS
  // Once the header has ended or failed, bytes without a restart leave only idle results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_sof_q && (phase_q == PH_DONE || phase_q == PH_ERROR)
    |=> status_o == ppmhp_pkg::ST_IDLE)
    else $error("idle parser produced a non-idle result");

  // An error code only accompanies an error status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ppmhp_pkg::ST_ERROR |-> error_code_o == ppmhp_pkg::ERR_NONE)
    else $error("error code without error status");

  // Header values are only shown with the end-of-header status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ppmhp_pkg::ST_END
    |-> header_length_o == 16'd0 && image_width_o == 16'd0 && max_value_o == 16'd0)
    else $error("header values outside end-of-header result");
`endif

endmodule
